### hdl/dmc_pkg.sv
// Shared constants, control word type and microcode table for the direct-mapped cache.
package dmc_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned LINE_COUNT = 4;
   localparam int unsigned MEM_WORDS  = 64;
   localparam int unsigned IDX_W      = $clog2(LINE_COUNT);
   localparam int unsigned TAG_W      = ADDR_W - IDX_W;
   localparam int unsigned MEM_AW     = $clog2(MEM_WORDS);

   localparam logic [WORD_W-1:0] MEM_INIT_BASE = 32'd1000;
   localparam logic [WORD_W-1:0] MEM_INIT_STEP = 32'd10;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   localparam int unsigned STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_LOOK  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_FETCH = 3'd2;
   localparam logic [STEP_W-1:0] STEP_INST  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_DONE  = 3'd4;

   localparam logic [1:0] COND_NEVER = 2'd0;
   localparam logic [1:0] COND_REQ   = 2'd1;
   localparam logic [1:0] COND_HIT   = 2'd2;
   localparam logic [1:0] COND_FREE  = 2'd3;

   typedef struct packed {
      logic              accept;
      logic              look;
      logic              fetch;
      logic              install;
      logic              finish;
      logic              hold;
      logic [1:0]        cond;
      logic [STEP_W-1:0] target;
   } uc_word_type;

   function automatic uc_word_type uc_rom(input logic [STEP_W-1:0] step);
      uc_word_type w;
      w = '0;
      case (step)
         STEP_IDLE: begin
            w.accept = 1'b1;
            w.hold   = 1'b1;
            w.cond   = COND_REQ;
            w.target = STEP_LOOK;
         end
         STEP_LOOK: begin
            w.look   = 1'b1;
            w.cond   = COND_HIT;
            w.target = STEP_DONE;
         end
         STEP_FETCH: begin
            w.fetch  = 1'b1;
            w.cond   = COND_NEVER;
            w.target = STEP_IDLE;
         end
         STEP_INST: begin
            w.install = 1'b1;
            w.cond    = COND_NEVER;
            w.target  = STEP_IDLE;
         end
         STEP_DONE: begin
            w.finish = 1'b1;
            w.hold   = 1'b1;
            w.cond   = COND_FREE;
            w.target = STEP_IDLE;
         end
         default: begin
            w.target = STEP_IDLE;
            w.cond   = COND_REQ;
         end
      endcase
      return w;
   endfunction

   function automatic logic [WORD_W-1:0] mem_init_word(input logic [MEM_AW-1:0] slot);
      logic [WORD_W-1:0] prod;
      prod = MEM_INIT_STEP * WORD_W'(slot);
      return MEM_INIT_BASE + prod;
   endfunction

endpackage

### hdl/dmc_ram.sv
// Generic single-port RAM with registered read data.
module dmc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic             rd_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/direct_mapped_write_back_cache.sv
// Direct-mapped write-back write-allocate cache with internal backing memory.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_func, req_address, req_write_data
//   rsp      out        rsp_valid / rsp_ready  rsp_hit, rsp_wrote_back, rsp_read_valid,
//                                              rsp_read_data
//
// A hit runs look then done; a miss runs look, fetch, install, done, as the backing
// RAM's single port keeps victim write, fetch read and registered read data apart.
// A new request is taken while the previous response still waits in the output register.
// A stalled response holds the sequencer at its last step until the output register frees.
// Reset is synchronous and takes effect with no clearing pass.
module direct_mapped_write_back_cache (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_address,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic        rsp_wrote_back,
   output logic        rsp_read_valid,
   output logic [31:0] rsp_read_data
);

   logic [dmc_pkg::STEP_W-1:0] step_ff;
   logic [dmc_pkg::STEP_W-1:0] step_in;
   dmc_pkg::uc_word_type       uc;
   logic                       cond_true;

   logic                       func_ff;
   logic [dmc_pkg::ADDR_W-1:0] addr_ff;
   logic [dmc_pkg::WORD_W-1:0] wdata_ff;
   logic                       hit_ff;
   logic                       wb_ff;
   logic                       fetch_vld_ff;

   logic [dmc_pkg::LINE_COUNT-1:0] valid_ff;
   logic [dmc_pkg::LINE_COUNT-1:0] dirty_ff;
   logic [dmc_pkg::TAG_W-1:0]      tag_ff  [dmc_pkg::LINE_COUNT];
   logic [dmc_pkg::WORD_W-1:0]     word_ff [dmc_pkg::LINE_COUNT];
   logic [dmc_pkg::MEM_WORDS-1:0]  mem_vld_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_hit_ff;
   logic                       rsp_wb_ff;
   logic                       rsp_rv_ff;
   logic [dmc_pkg::WORD_W-1:0] rsp_rdata_ff;

   logic [dmc_pkg::IDX_W-1:0]  line_idx;
   logic [dmc_pkg::TAG_W-1:0]  line_tag;
   logic                       hit_now;
   logic                       victim_now;
   logic [dmc_pkg::MEM_AW-1:0] victim_slot;
   logic [dmc_pkg::MEM_AW-1:0] fetch_slot;
   logic [dmc_pkg::ADDR_W-1:0] evict_addr;
   logic                       out_free;
   logic                       ram_wr_en;
   logic [dmc_pkg::MEM_AW-1:0] ram_addr;
   logic [dmc_pkg::WORD_W-1:0] ram_q;
   logic [dmc_pkg::WORD_W-1:0] fetched_word;

   assign uc        = dmc_pkg::uc_rom(step_ff);
   assign req_ready = uc.accept;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign line_idx    = addr_ff[dmc_pkg::IDX_W-1:0];
   assign line_tag    = addr_ff[dmc_pkg::ADDR_W-1:dmc_pkg::IDX_W];
   assign hit_now     = valid_ff[line_idx] && (tag_ff[line_idx] == line_tag);
   assign victim_now  = !hit_now && valid_ff[line_idx] && dirty_ff[line_idx];
   assign evict_addr  = {tag_ff[line_idx], line_idx};
   assign victim_slot = evict_addr[dmc_pkg::MEM_AW-1:0];
   assign fetch_slot  = addr_ff[dmc_pkg::MEM_AW-1:0];

   assign ram_wr_en = uc.look && victim_now;
   assign ram_addr  = ram_wr_en ? victim_slot : fetch_slot;
   assign fetched_word = fetch_vld_ff ? ram_q : dmc_pkg::mem_init_word(fetch_slot);

   dmc_ram #(
      .WIDTH (dmc_pkg::WORD_W),
      .DEPTH (dmc_pkg::MEM_WORDS)
   ) u_backing (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (uc.fetch),
      .addr    (ram_addr),
      .wr_data (word_ff[line_idx]),
      .rd_data (ram_q)
   );

   always_comb begin
      case (uc.cond)
         dmc_pkg::COND_NEVER: cond_true = 1'b0;
         dmc_pkg::COND_REQ:   cond_true = req_valid;
         dmc_pkg::COND_HIT:   cond_true = hit_now;
         dmc_pkg::COND_FREE:  cond_true = out_free;
         default:             cond_true = 1'b0;
      endcase
      if (cond_true) begin
         step_in = uc.target;
      end else if (uc.hold) begin
         step_in = step_ff;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= dmc_pkg::STEP_IDLE;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         mem_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (uc.finish && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ram_wr_en) begin
            mem_vld_ff[victim_slot] <= 1'b1;
         end
         if (uc.install) begin
            valid_ff[line_idx] <= 1'b1;
            dirty_ff[line_idx] <= 1'b0;
         end
         if (uc.finish && out_free && (func_ff == dmc_pkg::FUNC_WRITE)) begin
            dirty_ff[line_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (uc.accept && req_valid) begin
         func_ff  <= req_func;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
      end
      if (uc.look) begin
         hit_ff <= hit_now;
         wb_ff  <= victim_now;
      end
      if (uc.fetch) begin
         fetch_vld_ff <= mem_vld_ff[fetch_slot];
      end
      if (uc.install) begin
         tag_ff[line_idx]  <= line_tag;
         word_ff[line_idx] <= fetched_word;
      end
      if (uc.finish && out_free) begin
         rsp_hit_ff <= hit_ff;
         rsp_wb_ff  <= wb_ff;
         if (func_ff == dmc_pkg::FUNC_WRITE) begin
            word_ff[line_idx] <= wdata_ff;
            rsp_rv_ff         <= 1'b0;
            rsp_rdata_ff      <= '0;
         end else begin
            rsp_rv_ff    <= 1'b1;
            rsp_rdata_ff <= word_ff[line_idx];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_wrote_back = rsp_wb_ff;
   assign rsp_read_valid = rsp_rv_ff;
   assign rsp_read_data  = rsp_rdata_ff;

   // A new response is loaded only from the final step of the program.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff) == dmc_pkg::STEP_DONE)
      else $error("response loaded outside the final step");

   // A miss always continues to the fetch step.
   a_miss_fetches: assert property (@(posedge clock) disable iff (reset)
      (step_ff == dmc_pkg::STEP_LOOK && !hit_now) |=> step_ff == dmc_pkg::STEP_FETCH)
      else $error("miss did not proceed to fetch");

   // The installed line is valid with the requested tag.
   a_install_valid: assert property (@(posedge clock) disable iff (reset)
      step_ff == dmc_pkg::STEP_INST |=> hit_now)
      else $error("installed line does not hit");

   // A write-back only happens on a miss.
   a_wb_on_miss: assert property (@(posedge clock) disable iff (reset)
      step_ff == dmc_pkg::STEP_DONE |-> !(hit_ff && wb_ff))
      else $error("write-back reported on a hit");

endmodule

### tb/tb_direct_mapped_write_back_cache.sv
// Self-checking testbench for the direct-mapped write-back cache with a scoreboard class.
`timescale 1ns / 1ps

module tb_direct_mapped_write_back_cache;

   localparam int QUIET_LIMIT    = 2000;
   localparam int RANDOM_ITEMS   = 750;
   localparam int HOLD_OFF_START = 150;
   localparam int HOLD_OFF_LEN   = 200;

   class cache_scoreboard;
      typedef struct {
         logic        hit;
         logic        wrote_back;
         logic        read_valid;
         logic [31:0] read_data;
      } cache_answer_type;

      bit                         line_valid [dmc_pkg::LINE_COUNT];
      bit                         line_dirty [dmc_pkg::LINE_COUNT];
      logic [dmc_pkg::TAG_W-1:0]  line_tag   [dmc_pkg::LINE_COUNT];
      logic [31:0]                line_word  [dmc_pkg::LINE_COUNT];
      logic [31:0]                backing    [dmc_pkg::MEM_WORDS];
      cache_answer_type           answers_due[$];
      int                         mismatches;

      function new();
         for (int i = 0; i < dmc_pkg::LINE_COUNT; i++) begin
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_tag[i]   = '0;
            line_word[i]  = '0;
         end
         for (int i = 0; i < dmc_pkg::MEM_WORDS; i++) begin
            backing[i] = dmc_pkg::MEM_INIT_BASE + dmc_pkg::MEM_INIT_STEP * 32'(i);
         end
         mismatches = 0;
      endfunction

      function void note_request(logic func, logic [31:0] address, logic [31:0] write_data);
         logic [dmc_pkg::IDX_W-1:0] idx;
         logic [dmc_pkg::TAG_W-1:0] tag;
         logic [31:0]               victim;
         cache_answer_type          ans;
         idx = address[dmc_pkg::IDX_W-1:0];
         tag = address[dmc_pkg::ADDR_W-1:dmc_pkg::IDX_W];
         ans.hit        = line_valid[idx] && (line_tag[idx] == tag);
         ans.wrote_back = 1'b0;
         ans.read_valid = (func != dmc_pkg::FUNC_WRITE);
         ans.read_data  = '0;
         if (!ans.hit) begin
            if (line_valid[idx] && line_dirty[idx]) begin
               victim = {line_tag[idx], idx};
               backing[victim[dmc_pkg::MEM_AW-1:0]] = line_word[idx];
               ans.wrote_back = 1'b1;
            end
            line_word[idx]  = backing[address[dmc_pkg::MEM_AW-1:0]];
            line_tag[idx]   = tag;
            line_valid[idx] = 1'b1;
            line_dirty[idx] = 1'b0;
         end
         if (func == dmc_pkg::FUNC_WRITE) begin
            line_word[idx]  = write_data;
            line_dirty[idx] = 1'b1;
         end else begin
            ans.read_data = line_word[idx];
         end
         answers_due = {answers_due, ans};
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_response(logic hit, logic wrote_back, logic read_valid, logic [31:0] read_data);
         cache_answer_type want;
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("response transfer with nothing outstanding, data %h",
                                      read_data));
         end else begin
            want = answers_due.pop_front();
            if (hit !== want.hit)
               report_mismatch($sformatf("hit %b, expected %b", hit, want.hit));
            if (wrote_back !== want.wrote_back)
               report_mismatch($sformatf("wrote_back %b, expected %b",
                                         wrote_back, want.wrote_back));
            if (read_valid !== want.read_valid)
               report_mismatch($sformatf("read_valid %b, expected %b",
                                         read_valid, want.read_valid));
            if (read_data !== want.read_data)
               report_mismatch($sformatf("read_data %h, expected %h",
                                         read_data, want.read_data));
         end
      endtask

      task report_leftover();
         if (answers_due.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", answers_due.size()));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_func;
   logic [31:0] req_address;
   logic [31:0] req_write_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_hit;
   logic        rsp_wrote_back;
   logic        rsp_read_valid;
   logic [31:0] rsp_read_data;

   cache_scoreboard sb;
   bit              calm = 1'b0;
   bit              held_off = 1'b0;
   int              requests_taken = 0;
   int              quiet_cycles = 0;

   direct_mapped_write_back_cache i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_wrote_back (rsp_wrote_back),
      .rsp_read_valid (rsp_read_valid),
      .rsp_read_data  (rsp_read_data)
   );

   always #2 clock = ~clock;

   task send_request(input logic func, input logic [31:0] address, input logic [31:0] data);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_address    <= address;
      req_write_data <= data;
      do @(posedge clock); while (!req_ready);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_hit, rsp_wrote_back, rsp_read_valid, rsp_read_data);
         if (req_valid && req_ready) begin
            sb.note_request(req_func, req_address, req_write_data);
            requests_taken++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && requests_taken >= HOLD_OFF_START) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(negedge clock);
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 21);
         end
      end
   end

   initial begin
      int          kind;
      logic        func;
      logic [31:0] address;
      logic [31:0] data;

      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = dmc_pkg::FUNC_READ;
      req_address    = '0;
      req_write_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Clean misses, hits, dirty evictions and victims that alias the fetched word.
      send_request(dmc_pkg::FUNC_READ,  32'h0000_0000, 32'h0000_0000);
      send_request(dmc_pkg::FUNC_READ,  32'h0000_0000, 32'hFFFF_FFFF);
      send_request(dmc_pkg::FUNC_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(dmc_pkg::FUNC_READ,  32'h0000_0040, 32'h0000_0000);
      send_request(dmc_pkg::FUNC_WRITE, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(dmc_pkg::FUNC_READ,  32'hFFFF_FFFF, 32'h1234_5678);
      send_request(dmc_pkg::FUNC_WRITE, 32'h0000_003F, 32'hA5A5_A5A5);
      send_request(dmc_pkg::FUNC_READ,  32'h7FFF_FFFF, 32'h0000_0000);
      send_request(dmc_pkg::FUNC_WRITE, 32'h0000_0005, 32'h5A5A_5A5A);
      send_request(dmc_pkg::FUNC_WRITE, 32'h0000_0005, 32'h0F0F_0F0F);
      send_request(dmc_pkg::FUNC_READ,  32'h8000_0005, 32'h0000_0000);
      send_request(dmc_pkg::FUNC_READ,  32'h0000_0005, 32'h0000_0000);
      send_request(dmc_pkg::FUNC_WRITE, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_request(dmc_pkg::FUNC_WRITE, 32'h0000_0002, 32'h0000_0001);
      send_request(dmc_pkg::FUNC_READ,  32'hFFFF_FFFE, 32'h0000_0000);
      send_request(dmc_pkg::FUNC_READ,  32'h0000_0000, 32'h0000_0000);
      send_request(dmc_pkg::FUNC_READ,  32'h0000_0040, 32'h0000_0000);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 400 && n < 520);
         kind = $urandom_range(99);
         if (kind < 70)
            address = 32'(($urandom_range(31) << 2) | $urandom_range(3));
         else if (kind < 85)
            address = {($urandom_range(1) != 0) ? 25'h1FF_FFFF : 25'h0,
                       7'($urandom_range(127))};
         else
            address = $urandom();
         func = 1'($urandom_range(1));
         kind = $urandom_range(9);
         data = (kind == 0) ? 32'h0 : (kind == 1) ? 32'hFFFF_FFFF : $urandom();
         send_request(func, address, data);
      end
      calm = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.answers_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      sb.report_leftover();
      if (sb.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
